// File: design/krpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpwm_pkg
// Shared widths, register map, reset values, control/status structs and
// helpers for the knob-ramped PWM unit with knob calibration.
// ----------------------------------------------------------------------------
package krpwm_pkg;

    // Default converter resolution of the knob readings
    localparam int SAMPLE_BITS_DEF = 10;

    // Fixed field widths
    localparam int ELAPSED_W  = 10;
    localparam int TIME_W     = 16;
    localparam int DUTY_W     = 8;
    localparam int LED_W      = 8;
    localparam int STEP_W     = 8;
    localparam int MIN_SPAN_W = 10;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_DEADZONE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEP_MAX       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_MS  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CALIBRATION_MS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SPAN       = 3'd4;

    // Register reset values
    localparam logic [STEP_W-1:0]     DEADZONE_RST       = 8'd3;
    localparam logic [STEP_W-1:0]     STEP_MAX_RST       = 8'd10;
    localparam logic [TIME_W-1:0]     LONG_PRESS_MS_RST  = 16'd3000;
    localparam logic [TIME_W-1:0]     CALIBRATION_MS_RST = 16'd5000;
    localparam logic [MIN_SPAN_W-1:0] MIN_SPAN_RST       = 10'd50;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;
    localparam logic [LED_W-1:0]  LED_ON   = '1;
    localparam logic [LED_W-1:0]  LED_OFF  = '0;

    // Configuration register values
    typedef struct packed {
        logic [STEP_W-1:0]     deadzone;
        logic [STEP_W-1:0]     step_max;
        logic [TIME_W-1:0]     long_press_ms;
        logic [TIME_W-1:0]     calibration_ms;
        logic [MIN_SPAN_W-1:0] min_span;
    } t_cfg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic front;
        logic finish;
        logic clamp;
        logic mul;
        logic div_start;
        logic apply;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
    } t_sts;

    // Millisecond accumulation, saturating at the top of the timer range
    function automatic logic [TIME_W-1:0] add_sat_time(input logic [TIME_W-1:0]    a,
                                                       input logic [ELAPSED_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

// File: design/krpwm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpwm_in_if
// Sample channel: knob readings, button level and elapsed time per word.
// ----------------------------------------------------------------------------
interface krpwm_in_if #(
    parameter int SAMPLE_BITS = krpwm_pkg::SAMPLE_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic [SAMPLE_BITS-1:0]             knob_up;
    logic [SAMPLE_BITS-1:0]             knob_down;
    logic                               button_down;
    logic [krpwm_pkg::ELAPSED_W-1:0]    elapsed_ms;

    modport source (
        output valid, knob_up, knob_down, button_down, elapsed_ms,
        input  ready
    );

    modport sink (
        input  valid, knob_up, knob_down, button_down, elapsed_ms,
        output ready
    );
endinterface

// File: design/krpwm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpwm_out_if
// Result channel: PWM duty, status LED levels and status flags per word.
// ----------------------------------------------------------------------------
interface krpwm_out_if;
    logic                           valid;
    logic                           ready;
    logic [krpwm_pkg::DUTY_W-1:0]   duty;
    logic [krpwm_pkg::LED_W-1:0]    led_red;
    logic [krpwm_pkg::LED_W-1:0]    led_green;
    logic [krpwm_pkg::LED_W-1:0]    led_blue;
    logic                           running;
    logic                           in_calibration;
    logic                           duty_changed;

    modport source (
        output valid, duty, led_red, led_green, led_blue, running, in_calibration,
               duty_changed,
        input  ready
    );

    modport sink (
        input  valid, duty, led_red, led_green, led_blue, running, in_calibration,
               duty_changed,
        output ready
    );
endinterface

// File: design/knob_ramped_pwm_with_calibration_unit.sv
`timescale 1ns / 1ps
// An accepted sample word passes the states FRONT, FIN, CLAMP, MUL, DSTART, DWAIT
//   and APPLY before its result word is valid; the sequencer handles one word at a
//   time, and the two 8-step knob dividers in DWAIT run side by side.
// A new word is taken while the previous result still waits in the output register.
// Reset (synchronous, active low): registers to defaults, duty 0, active, full knob
//   ranges, no calibration; no clearing pass, input ready as soon as reset is released.
// ----------------------------------------------------------------------------
// knob_ramped_pwm_with_calibration_unit
// Knob-ramped PWM duty with button-started knob calibration, status LED
// levels and an APB-style register port.
// ----------------------------------------------------------------------------
module knob_ramped_pwm_with_calibration_unit #(
    parameter int SAMPLE_BITS = krpwm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    krpwm_in_if.sink                         i_sample,
    krpwm_out_if.source                      o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [krpwm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [krpwm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [krpwm_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    localparam int AW = krpwm_pkg::APB_ADDR_W;
    localparam int DW = krpwm_pkg::APB_DATA_W;

    krpwm_pkg::t_cfg                      r_cfg;
    krpwm_pkg::t_cmd                      cmd;
    krpwm_pkg::t_sts                      sts;
    logic [krpwm_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadzone       <= krpwm_pkg::DEADZONE_RST;
            r_cfg.step_max       <= krpwm_pkg::STEP_MAX_RST;
            r_cfg.long_press_ms  <= krpwm_pkg::LONG_PRESS_MS_RST;
            r_cfg.calibration_ms <= krpwm_pkg::CALIBRATION_MS_RST;
            r_cfg.min_span       <= krpwm_pkg::MIN_SPAN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                krpwm_pkg::REG_DEADZONE:
                    r_cfg.deadzone <= pwdata[krpwm_pkg::STEP_W-1:0];
                krpwm_pkg::REG_STEP_MAX:
                    r_cfg.step_max <= pwdata[krpwm_pkg::STEP_W-1:0];
                krpwm_pkg::REG_LONG_PRESS_MS:
                    r_cfg.long_press_ms <= pwdata[krpwm_pkg::TIME_W-1:0];
                krpwm_pkg::REG_CALIBRATION_MS:
                    r_cfg.calibration_ms <= pwdata[krpwm_pkg::TIME_W-1:0];
                krpwm_pkg::REG_MIN_SPAN:
                    r_cfg.min_span <= pwdata[krpwm_pkg::MIN_SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            krpwm_pkg::REG_DEADZONE:       prdata = DW'(r_cfg.deadzone);
            krpwm_pkg::REG_STEP_MAX:       prdata = DW'(r_cfg.step_max);
            krpwm_pkg::REG_LONG_PRESS_MS:  prdata = DW'(r_cfg.long_press_ms);
            krpwm_pkg::REG_CALIBRATION_MS: prdata = DW'(r_cfg.calibration_ms);
            krpwm_pkg::REG_MIN_SPAN:       prdata = DW'(r_cfg.min_span);
            default:                       prdata = '0;
        endcase
    end

    krpwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    krpwm_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg            (r_cfg),
        .i_knob_up        (i_sample.knob_up),
        .i_knob_down      (i_sample.knob_down),
        .i_button_down    (i_sample.button_down),
        .i_elapsed_ms     (i_sample.elapsed_ms),
        .o_duty           (o_result.duty),
        .o_led_red        (o_result.led_red),
        .o_led_green      (o_result.led_green),
        .o_led_blue       (o_result.led_blue),
        .o_running        (o_result.running),
        .o_in_calibration (o_result.in_calibration),
        .o_duty_changed   (o_result.duty_changed)
    );

endmodule

// File: design/krpwm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpwm_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in STEP_W bits (numerator below divisor times 2^STEP_W).
// ----------------------------------------------------------------------------
module krpwm_div #(
    parameter int SAMPLE_BITS = krpwm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [SAMPLE_BITS+krpwm_pkg::STEP_W-1:0] i_num,
    input  logic [SAMPLE_BITS-1:0]                  i_den,
    output logic [krpwm_pkg::STEP_W-1:0]            o_quot,
    output logic                                    o_done
);
    localparam int Q_W   = krpwm_pkg::STEP_W;
    localparam int NUM_W = SAMPLE_BITS + Q_W;
    localparam int CNT_W = $clog2(Q_W);

    logic [SAMPLE_BITS-1:0] r_rem;
    logic [Q_W-1:0]         r_shift;
    logic [Q_W-1:0]         r_quot;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   trial_diff;
    logic                   q_bit;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial      = {r_rem, r_shift[Q_W-1]};
    assign trial_diff = trial - {1'b0, i_den};
    assign q_bit      = (trial >= {1'b0, i_den});

    // Control: busy for Q_W steps, done level until the next start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(Q_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load the upper numerator bits, then shift in one bit a step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num[NUM_W-1:Q_W];
            r_shift <= i_num[Q_W-1:0];
            r_quot  <= '0;
        end else if (r_busy) begin
            r_rem   <= q_bit ? trial_diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            r_shift <= {r_shift[Q_W-2:0], 1'b0};
            r_quot  <= {r_quot[Q_W-2:0], q_bit};
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// File: design/krpwm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpwm_dp
// Datapath: button timing, calibration window and range tracking, knob
// clamp and scaling (multiply then divide), duty ramp and result register.
// ----------------------------------------------------------------------------
module krpwm_dp #(
    parameter int SAMPLE_BITS = krpwm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  krpwm_pkg::t_cmd                 i_cmd,
    output krpwm_pkg::t_sts                 o_sts,
    input  krpwm_pkg::t_cfg                 i_cfg,
    input  logic [SAMPLE_BITS-1:0]          i_knob_up,
    input  logic [SAMPLE_BITS-1:0]          i_knob_down,
    input  logic                            i_button_down,
    input  logic [krpwm_pkg::ELAPSED_W-1:0] i_elapsed_ms,
    output logic [krpwm_pkg::DUTY_W-1:0]    o_duty,
    output logic [krpwm_pkg::LED_W-1:0]     o_led_red,
    output logic [krpwm_pkg::LED_W-1:0]     o_led_green,
    output logic [krpwm_pkg::LED_W-1:0]     o_led_blue,
    output logic                            o_running,
    output logic                            o_in_calibration,
    output logic                            o_duty_changed
);
    localparam int SB    = SAMPLE_BITS;
    localparam int NUM_W = SB + krpwm_pkg::STEP_W;
    localparam int CMP_W = (SB > krpwm_pkg::MIN_SPAN_W) ? SB : krpwm_pkg::MIN_SPAN_W;
    localparam logic [SB-1:0] KNOB_MAX = '1;

    // Latched input word
    logic [SB-1:0]                   r_u, r_d;
    logic                            r_btn;
    logic [krpwm_pkg::ELAPSED_W-1:0] r_el;

    // Persistent state
    logic [krpwm_pkg::DUTY_W-1:0] r_duty;
    logic                         r_active, n_active;
    logic                         r_held, n_held;
    logic [krpwm_pkg::TIME_W-1:0] r_hold_time, n_hold_time;
    logic                         r_cal, n_cal;
    logic [krpwm_pkg::TIME_W-1:0] r_cal_time, n_cal_time;
    logic [SB-1:0]                r_up_lo, n_up_lo, r_up_hi, n_up_hi;
    logic [SB-1:0]                r_dn_lo, n_dn_lo, r_dn_hi, n_dn_hi;
    logic                         r_cal_out, n_cal_out;
    logic                         r_fin, n_fin;

    // Scaling pipeline
    logic [SB-1:0]    r_diff_u, r_diff_d, r_span_u, r_span_d;
    logic             r_zero_u, r_zero_d;
    logic [NUM_W-1:0] r_prod_u, r_prod_d;

    // Result register
    logic [krpwm_pkg::DUTY_W-1:0] r_o_duty;
    logic [krpwm_pkg::LED_W-1:0]  r_o_red, r_o_green, r_o_blue;
    logic                         r_o_running, r_o_cal, r_o_changed;

    logic [krpwm_pkg::TIME_W-1:0] cal_sum, press_len;
    logic [SB-1:0]                span_u, span_d, clamp_u, clamp_d;
    logic [krpwm_pkg::STEP_W-1:0] quot_u, quot_d, step_u, step_d;
    logic                         done_u, done_d;
    logic [krpwm_pkg::DUTY_W:0]   duty_sum;
    logic [krpwm_pkg::DUTY_W-1:0] duty_up, duty_dn;

    assign cal_sum   = krpwm_pkg::add_sat_time(r_cal_time, r_el);
    assign press_len = krpwm_pkg::add_sat_time(r_hold_time, r_el);
    assign span_u    = r_up_hi - r_up_lo;
    assign span_d    = r_dn_hi - r_dn_lo;

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_u   <= i_knob_up;
            r_d   <= i_knob_down;
            r_btn <= i_button_down;
            r_el  <= i_elapsed_ms;
        end
    end

    // Button timing, calibration window and range bookkeeping
    always_comb begin
        n_active    = r_active;
        n_held      = r_held;
        n_hold_time = r_hold_time;
        n_cal       = r_cal;
        n_cal_time  = r_cal_time;
        n_up_lo     = r_up_lo;
        n_up_hi     = r_up_hi;
        n_dn_lo     = r_dn_lo;
        n_dn_hi     = r_dn_hi;
        n_cal_out   = r_cal_out;
        n_fin       = r_fin;
        if (i_cmd.front) begin
            n_cal_out = 1'b0;
            n_fin     = 1'b0;
            if (r_cal) begin
                // Window running: track both knobs until time runs out
                n_cal_time = cal_sum;
                if (cal_sum < i_cfg.calibration_ms) begin
                    if (r_u < r_up_lo) n_up_lo = r_u;
                    if (r_u > r_up_hi) n_up_hi = r_u;
                    if (r_d < r_dn_lo) n_dn_lo = r_d;
                    if (r_d > r_dn_hi) n_dn_hi = r_d;
                    n_cal_out = 1'b1;
                end else begin
                    n_fin = 1'b1;
                end
            end else if (r_btn && !r_held) begin
                n_held      = 1'b1;
                n_hold_time = '0;
            end else if (r_btn) begin
                n_hold_time = press_len;
            end else if (r_held) begin
                // Release: long press opens the window, short press toggles
                n_held = 1'b0;
                if (press_len >= i_cfg.long_press_ms) begin
                    n_cal      = 1'b1;
                    n_cal_time = '0;
                    if (i_cfg.calibration_ms != '0) begin
                        n_up_lo   = r_u;
                        n_up_hi   = r_u;
                        n_dn_lo   = r_d;
                        n_dn_hi   = r_d;
                        n_cal_out = 1'b1;
                    end else begin
                        n_up_lo = KNOB_MAX;
                        n_up_hi = '0;
                        n_dn_lo = KNOB_MAX;
                        n_dn_hi = '0;
                        n_fin   = 1'b1;
                    end
                end else begin
                    n_active = !r_active;
                end
            end
        end else if (i_cmd.finish && r_fin) begin
            // Close the window; narrow or empty ranges fall back to full scale
            n_cal = 1'b0;
            if ((r_up_hi < r_up_lo) ||
                (CMP_W'(span_u) < CMP_W'(i_cfg.min_span))) begin
                n_up_lo = '0;
                n_up_hi = KNOB_MAX;
            end
            if ((r_dn_hi < r_dn_lo) ||
                (CMP_W'(span_d) < CMP_W'(i_cfg.min_span))) begin
                n_dn_lo = '0;
                n_dn_hi = KNOB_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b1;
            r_held      <= 1'b0;
            r_hold_time <= '0;
            r_cal       <= 1'b0;
            r_cal_time  <= '0;
            r_up_lo     <= '0;
            r_up_hi     <= KNOB_MAX;
            r_dn_lo     <= '0;
            r_dn_hi     <= KNOB_MAX;
            r_cal_out   <= 1'b0;
            r_fin       <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_held      <= n_held;
            r_hold_time <= n_hold_time;
            r_cal       <= n_cal;
            r_cal_time  <= n_cal_time;
            r_up_lo     <= n_up_lo;
            r_up_hi     <= n_up_hi;
            r_dn_lo     <= n_dn_lo;
            r_dn_hi     <= n_dn_hi;
            r_cal_out   <= n_cal_out;
            r_fin       <= n_fin;
        end
    end

    // Clamp each knob into its calibrated range
    assign clamp_u = (r_u < r_up_lo) ? r_up_lo : ((r_u > r_up_hi) ? r_up_hi : r_u);
    assign clamp_d = (r_d < r_dn_lo) ? r_dn_lo : ((r_d > r_dn_hi) ? r_dn_hi : r_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_diff_u <= clamp_u - r_up_lo;
            r_diff_d <= clamp_d - r_dn_lo;
            r_span_u <= span_u;
            r_span_d <= span_d;
            r_zero_u <= (r_up_hi <= r_up_lo);
            r_zero_d <= (r_dn_hi <= r_dn_lo);
        end
    end

    // Scale offset by the largest step before the division
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_u <= NUM_W'(r_diff_u) * NUM_W'(i_cfg.step_max);
            r_prod_d <= NUM_W'(r_diff_d) * NUM_W'(i_cfg.step_max);
        end
    end

    krpwm_div #(.SAMPLE_BITS(SB)) u_div_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod_u),
        .i_den   (r_span_u),
        .o_quot  (quot_u),
        .o_done  (done_u)
    );

    krpwm_div #(.SAMPLE_BITS(SB)) u_div_down (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod_d),
        .i_den   (r_span_d),
        .o_quot  (quot_d),
        .o_done  (done_d)
    );

    assign o_sts.div_done = done_u && done_d;

    // Zero-width range scales to no step
    assign step_u   = r_zero_u ? '0 : quot_u;
    assign step_d   = r_zero_d ? '0 : quot_d;
    assign duty_sum = {1'b0, r_duty} + {1'b0, step_u};
    assign duty_up  = duty_sum[krpwm_pkg::DUTY_W] ? krpwm_pkg::DUTY_MAX
                                                  : duty_sum[krpwm_pkg::DUTY_W-1:0];
    assign duty_dn  = (step_d >= r_duty) ? '0 : (r_duty - step_d);

    // Duty ramp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= '0;
        end else if (i_cmd.apply && !r_cal_out && r_active) begin
            if (step_u > i_cfg.deadzone) begin
                r_duty <= duty_up;
            end else if (step_d > i_cfg.deadzone) begin
                r_duty <= duty_dn;
            end
        end
    end

    // Build the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_o_running <= r_active;
            r_o_cal     <= r_cal_out;
            r_o_red     <= krpwm_pkg::LED_OFF;
            r_o_green   <= krpwm_pkg::LED_OFF;
            r_o_blue    <= krpwm_pkg::LED_OFF;
            r_o_changed <= 1'b0;
            r_o_duty    <= '0;
            if (r_cal_out) begin
                r_o_duty <= r_active ? r_duty : '0;
                r_o_red  <= krpwm_pkg::LED_ON;
                r_o_blue <= krpwm_pkg::LED_ON;
            end else if (!r_active) begin
                r_o_blue <= krpwm_pkg::LED_ON;
            end else if (step_u > i_cfg.deadzone) begin
                r_o_duty    <= duty_up;
                r_o_green   <= duty_up;
                r_o_changed <= 1'b1;
            end else if (step_d > i_cfg.deadzone) begin
                r_o_duty    <= duty_dn;
                r_o_red     <= duty_dn;
                r_o_changed <= 1'b1;
            end else begin
                r_o_duty <= r_duty;
            end
        end
    end

    assign o_duty           = r_o_duty;
    assign o_led_red        = r_o_red;
    assign o_led_green      = r_o_green;
    assign o_led_blue       = r_o_blue;
    assign o_running        = r_o_running;
    assign o_in_calibration = r_o_cal;
    assign o_duty_changed   = r_o_changed;

endmodule

// File: design/krpwm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krpwm_ctrl
// Sequencer: takes one sample word, steps the datapath through its phases
// and hands the result to the output register when that register is free.
// ----------------------------------------------------------------------------
module krpwm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output krpwm_pkg::t_cmd  o_cmd,
    input  krpwm_pkg::t_sts  i_sts
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FRONT  = 8'b0000_0010,
        S_FIN    = 8'b0000_0100,
        S_CLAMP  = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_DSTART = 8'b0010_0000,
        S_DWAIT  = 8'b0100_0000,
        S_APPLY  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = S_FRONT;
            end
            S_FRONT: begin
                o_cmd.front = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) n_state = S_APPLY;
            end
            S_APPLY: begin
                // Hold until the result register can take the new word
                o_cmd.apply = out_free;
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
